/* rtl/i2c_bit_level_master_top_defines.svh */
// ----------------------------------------------------------------------------
// i2c bit level master assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define I2CBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CBM_ASSERT(lbl, prop, msg)
`define I2CBM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/i2cbm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbm_pkg
// types and constants shared by the i2c bit level master
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int DIVIDER_WIDTH = 16;
    localparam int HALF_W        = 16;
    localparam int TIMEOUT_W     = 8;
    localparam int BYTE_W        = 8;
    localparam int KIND_W        = 3;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int BITCNT_W      = 4;
    localparam int CMP_W         = (DIVIDER_WIDTH > HALF_W) ? DIVIDER_WIDTH : HALF_W;

    localparam logic [CMP_W-1:0] CNT_MASK =
        CMP_W'((64'd1 << DIVIDER_WIDTH) - 64'd1);

    localparam logic [HALF_W-1:0]    HALF_RESET    = HALF_W'(10);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);
    localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE = BITCNT_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_PERIOD = 8'd0,
        REG_ACK_TIMEOUT = 8'd1
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 3'd0,
        KIND_STOP  = 3'd1,
        KIND_WRITE = 3'd2,
        KIND_READ  = 3'd3,
        KIND_WAIT  = 3'd4,
        KIND_ACK   = 3'd5,
        KIND_NACK  = 3'd6
    } cmd_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_STOP_A  = 4'd3,
        PH_STOP_B  = 4'd4,
        PH_WR_LOW  = 4'd5,
        PH_WR_HIGH = 4'd6,
        PH_RD_LOW  = 4'd7,
        PH_RD_HIGH = 4'd8,
        PH_RD_TAIL = 4'd9,
        PH_WA_LOW  = 4'd10,
        PH_WA_HIGH = 4'd11,
        PH_WA_WAIT = 4'd12,
        PH_AK_LOW  = 4'd13,
        PH_AK_HIGH = 4'd14
    } phase_t;

endpackage

/* rtl/i2cbm_ifs.sv */
// ----------------------------------------------------------------------------
// i2cbm channel interfaces
// valid/ready channels for command, result and configuration words
// ----------------------------------------------------------------------------
interface i2cbm_cmd_if;
    import i2cbm_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd_valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] cmd_byte;
    logic              sda_in;
    modport source (output valid, cmd_valid, kind, cmd_byte, sda_in, input ready);
    modport sink   (input valid, cmd_valid, kind, cmd_byte, sda_in, output ready);
endinterface

interface i2cbm_res_if;
    import i2cbm_pkg::*;
    logic              valid;
    logic              ready;
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_value;
    logic              ack_missing;
    modport source (output valid, scl_out, sda_out, busy_res, done_res, read_value,
                    ack_missing, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_value,
                    ack_missing, output ready);
endinterface

interface i2cbm_cfg_if;
    import i2cbm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/i2c_bit_level_master_top.sv */
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top
// i2c master that steps scl/sda through start, stop, byte write, byte read,
// acknowledge wait and ack/nack, one bus tick per command word
// ----------------------------------------------------------------------------
// Each command word is one tick of bus timing and yields exactly one result
// word with the scl/sda drive levels, busy, done, the last read byte and the
// missing-acknowledge flag. One word is accepted every clock cycle: the tick
// update is a single pass from the state registers into the result register,
// and that result register frees itself in the same cycle it is taken, so
// input stalls only while a result waits unread. A result appears in the cycle
// after its command word. Configuration writes are taken at once, ready high.
`include "i2c_bit_level_master_top_defines.svh"

module i2c_bit_level_master_top (
    input  logic         clk,
    input  logic         rst_n,
    i2cbm_cmd_if.sink    cmd,
    i2cbm_res_if.source  res,
    i2cbm_cfg_if.sink    cfg
);
    import i2cbm_pkg::*;

    phase_t                     phase_reg, phase_next;
    logic [BITCNT_W-1:0]        bit_count_reg, bit_count_next;
    logic [DIVIDER_WIDTH-1:0]   tick_count_reg, tick_count_next, tick_inc;
    logic [BYTE_W-1:0]          shift_reg, shift_next;
    logic [TIMEOUT_W-1:0]       wait_count_reg, wait_count_next;
    logic                       scl_level_reg, scl_level_next;
    logic                       sda_level_reg, sda_level_next;
    logic                       ack_flag_reg, ack_flag_next;
    logic [BYTE_W-1:0]          read_hold_reg, read_hold_next;
    logic [HALF_W-1:0]          half_period_reg;
    logic [TIMEOUT_W-1:0]       ack_timeout_reg;

    logic                       res_valid_reg;
    logic                       res_scl_reg, res_sda_reg, res_busy_reg, res_done_reg;
    logic [BYTE_W-1:0]          res_read_reg;
    logic                       res_ack_reg;

    logic                       go;
    logic                       idle;
    logic                       start_cmd;
    logic                       half_end;
    logic                       done_c;
    logic [BITCNT_W-1:0]        bit_inc;
    logic [BYTE_W-1:0]          shift_wr, shift_rd;
    logic [CMP_W-1:0]           hp_ext, eff_half;
    cmd_kind_t                  kind_c;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign go        = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign kind_c    = cmd_kind_t'(cmd.kind);
    assign idle      = (phase_reg == PH_IDLE);
    assign start_cmd = idle && cmd.cmd_valid && (cmd.kind <= KIND_NACK);
    assign tick_inc  = tick_count_reg + DIVIDER_WIDTH'(1);
    assign bit_inc   = bit_count_reg + BITCNT_W'(1);
    assign shift_wr  = {shift_reg[BYTE_W-2:0], 1'b0};
    assign shift_rd  = {shift_reg[BYTE_W-2:0], cmd.sda_in};

    // effective half period: zero counts as one, clamp to counter range
    always_comb
    begin
        hp_ext = CMP_W'(half_period_reg);
        if (hp_ext == '0)
        begin
            eff_half = CMP_W'(1);
        end
        else if (hp_ext > CNT_MASK)
        begin
            eff_half = CNT_MASK;
        end
        else
        begin
            eff_half = hp_ext;
        end
    end

    assign half_end = !idle && (CMP_W'(tick_inc) >= eff_half);
    assign done_c   = half_end && (phase_next == PH_IDLE);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (start_cmd)
        begin
            unique case (kind_c)
                KIND_START: phase_next = PH_START_A;
                KIND_STOP:  phase_next = PH_STOP_A;
                KIND_WRITE: phase_next = PH_WR_LOW;
                KIND_READ:  phase_next = PH_RD_LOW;
                KIND_WAIT:  phase_next = PH_WA_LOW;
                KIND_ACK:   phase_next = PH_AK_LOW;
                KIND_NACK:  phase_next = PH_AK_LOW;
                default:    phase_next = phase_reg;
            endcase
        end
        else if (half_end)
        begin
            unique case (phase_reg)
                PH_START_A: phase_next = PH_START_B;
                PH_STOP_A:  phase_next = PH_STOP_B;
                PH_WR_LOW:  phase_next = PH_WR_HIGH;
                PH_WR_HIGH: phase_next = (bit_inc >= BITS_PER_BYTE) ? PH_IDLE : PH_WR_LOW;
                PH_RD_LOW:  phase_next = PH_RD_HIGH;
                PH_RD_HIGH: phase_next = (bit_inc >= BITS_PER_BYTE) ? PH_RD_TAIL : PH_RD_LOW;
                PH_WA_LOW:  phase_next = PH_WA_HIGH;
                PH_WA_HIGH: phase_next = cmd.sda_in ? PH_WA_WAIT : PH_IDLE;
                PH_WA_WAIT:
                begin
                    if (wait_count_reg >= ack_timeout_reg || !cmd.sda_in)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_WA_WAIT;
                    end
                end
                PH_AK_LOW:  phase_next = PH_AK_HIGH;
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath and line levels
    always_comb
    begin
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        shift_next      = shift_reg;
        wait_count_next = wait_count_reg;
        scl_level_next  = scl_level_reg;
        sda_level_next  = sda_level_reg;
        ack_flag_next   = ack_flag_reg;
        read_hold_next  = read_hold_reg;
        if (start_cmd)
        begin
            tick_count_next = '0;
            bit_count_next  = '0;
            unique case (kind_c)
                KIND_START:
                begin
                    scl_level_next = 1'b1;
                    sda_level_next = 1'b1;
                end
                KIND_STOP:
                begin
                    scl_level_next = 1'b1;
                    sda_level_next = 1'b0;
                end
                KIND_WRITE:
                begin
                    shift_next     = cmd.cmd_byte;
                    scl_level_next = 1'b0;
                    sda_level_next = cmd.cmd_byte[BYTE_W-1];
                end
                KIND_READ:
                begin
                    shift_next     = '0;
                    scl_level_next = 1'b0;
                    sda_level_next = 1'b1;
                end
                KIND_WAIT:
                begin
                    wait_count_next = '0;
                    scl_level_next  = 1'b0;
                    sda_level_next  = 1'b1;
                end
                KIND_ACK:
                begin
                    scl_level_next = 1'b0;
                    sda_level_next = 1'b0;
                end
                KIND_NACK:
                begin
                    scl_level_next = 1'b0;
                    sda_level_next = 1'b1;
                end
                default:
                begin
                    scl_level_next = scl_level_reg;
                end
            endcase
        end
        else if (!idle)
        begin
            tick_count_next = half_end ? '0 : tick_inc;
            if (half_end)
            begin
                unique case (phase_reg)
                    PH_START_A: sda_level_next = 1'b0;
                    PH_STOP_A:  sda_level_next = 1'b1;
                    PH_WR_LOW:  scl_level_next = 1'b1;
                    PH_WR_HIGH:
                    begin
                        bit_count_next = bit_inc;
                        shift_next     = shift_wr;
                        if (bit_inc < BITS_PER_BYTE)
                        begin
                            scl_level_next = 1'b0;
                            sda_level_next = shift_wr[BYTE_W-1];
                        end
                    end
                    PH_RD_LOW:  scl_level_next = 1'b1;
                    PH_RD_HIGH:
                    begin
                        shift_next     = shift_rd;
                        bit_count_next = bit_inc;
                        scl_level_next = 1'b0;
                        if (bit_inc >= BITS_PER_BYTE)
                        begin
                            read_hold_next = shift_rd;
                        end
                    end
                    PH_WA_LOW:  scl_level_next = 1'b1;
                    PH_WA_HIGH:
                    begin
                        if (!cmd.sda_in)
                        begin
                            ack_flag_next  = 1'b0;
                            scl_level_next = 1'b0;
                        end
                        else
                        begin
                            wait_count_next = '0;
                        end
                    end
                    PH_WA_WAIT:
                    begin
                        if (wait_count_reg >= ack_timeout_reg)
                        begin
                            ack_flag_next  = 1'b1;
                            scl_level_next = 1'b0;
                        end
                        else
                        begin
                            wait_count_next = wait_count_reg + TIMEOUT_W'(1);
                            if (!cmd.sda_in)
                            begin
                                ack_flag_next  = 1'b0;
                                scl_level_next = 1'b0;
                            end
                        end
                    end
                    PH_AK_LOW:  scl_level_next = 1'b1;
                    PH_AK_HIGH: scl_level_next = 1'b0;
                    default:    scl_level_next = scl_level_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            tick_count_reg <= '0;
            shift_reg      <= '0;
            wait_count_reg <= '0;
            scl_level_reg  <= 1'b1;
            sda_level_reg  <= 1'b1;
            ack_flag_reg   <= 1'b0;
            read_hold_reg  <= '0;
        end
        else if (go)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            tick_count_reg <= tick_count_next;
            shift_reg      <= shift_next;
            wait_count_reg <= wait_count_next;
            scl_level_reg  <= scl_level_next;
            sda_level_reg  <= sda_level_next;
            ack_flag_reg   <= ack_flag_next;
            read_hold_reg  <= read_hold_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_RESET;
            ack_timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_HALF_PERIOD)
            begin
                half_period_reg <= cfg.data[HALF_W-1:0];
            end
            else if (cfg.index == REG_ACK_TIMEOUT)
            begin
                ack_timeout_reg <= cfg.data[TIMEOUT_W-1:0];
            end
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_scl_reg  <= scl_level_next;
            res_sda_reg  <= sda_level_next;
            res_busy_reg <= (phase_next != PH_IDLE);
            res_done_reg <= done_c;
            res_read_reg <= read_hold_next;
            res_ack_reg  <= ack_flag_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.scl_out     = res_scl_reg;
    assign res.sda_out     = res_sda_reg;
    assign res.busy_res    = res_busy_reg;
    assign res.done_res    = res_done_reg;
    assign res.read_value  = res_read_reg;
    assign res.ack_missing = res_ack_reg;

    `I2CBM_ASSERT_ALWAYS(a_cfg_ready, cfg.ready, "config not ready")
    `I2CBM_ASSERT(a_bit_count_range, bit_count_reg <= BITS_PER_BYTE, "bit count past byte")
    `I2CBM_ASSERT(a_stall_hold, (res_valid_reg && !res.ready) |-> !cmd.ready, "taken on stall")
    `I2CBM_ASSERT(a_done_not_busy, (res_valid_reg && res_done_reg) |-> !res_busy_reg, "busy on done")
    `I2CBM_ASSERT(a_done_goes_idle, (go && done_c) |=> (phase_reg == PH_IDLE), "idle missed")
    `I2CBM_ASSERT(a_tick_restart, (go && half_end) |=> (tick_count_reg == '0), "tick not restarted")

endmodule
